### src/scr_pkg.sv
package scr_pkg;

    localparam int PROFILE_WORDS = 256;
    localparam int PROFILE_AW    = $clog2(PROFILE_WORDS);
    localparam int WADDR_W       = 11;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    localparam logic [2:0] CFG_STOP_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_MAX_SPEED      = 3'd1;
    localparam logic [2:0] CFG_STOP_POSITION  = 3'd2;
    localparam logic [2:0] CFG_START_POSITION = 3'd3;
    localparam logic [2:0] CFG_INITIAL_SPEED  = 3'd4;
    localparam logic [2:0] CFG_INITIAL_STEPS  = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] table_value;
        logic [7:0]  table_index;
        logic        count_up;
    } scr_item_t;

    typedef struct packed {
        logic        moving;
        logic        halted;
        logic        speed_changed;
        logic [15:0] speed;
        logic [31:0] position;
    } scr_result_t;

    typedef struct packed {
        logic        stop_enable;
        logic [15:0] max_speed;
        logic [31:0] stop_position;
        logic [31:0] start_position;
        logic [15:0] initial_speed;
        logic [30:0] initial_steps;
    } scr_cfg_t;

endpackage

### src/scr_profile_ram.sv
module scr_profile_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### src/scr_ramp_unit.sv
module scr_ramp_unit
    import scr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  scr_item_t   item,
    input  scr_cfg_t    cfg,
    input  logic [15:0] seg_speed,
    input  logic [15:0] seg_steps,
    output logic [7:0]  seg_index,
    output scr_result_t result
);

    logic [31:0] pos_reg, pos_next;
    logic        active_reg, active_next;
    logic        up_reg, up_next;
    logic [7:0]  seg_reg, seg_next;
    logic [15:0] speed_reg, speed_next;
    logic [31:0] thr_reg, thr_next;
    logic [15:0] count_reg, count_next;

    logic [31:0] pos_step;
    logic [31:0] travel;
    logic        halt_hit;
    logic        ramp_hit;
    logic        is_tick;
    logic [15:0] clamped_speed;

    always_comb begin
        pos_step = up_reg ? (pos_reg + 32'd1) : (pos_reg - 32'd1);
        travel   = up_reg ? (pos_step - cfg.start_position) : (cfg.start_position - pos_step);
        if (up_reg) begin
            halt_hit = cfg.stop_enable && ($signed(cfg.stop_position) <= $signed(pos_step));
        end else begin
            halt_hit = cfg.stop_enable && ($signed(cfg.stop_position) >= $signed(pos_step));
        end
        ramp_hit = (speed_reg < cfg.max_speed) && ({8'd0, seg_reg} < count_reg)
                   && ($signed(travel) >= $signed(thr_reg));
        clamped_speed = (seg_speed > cfg.max_speed) ? cfg.max_speed : seg_speed;
        is_tick = (item.func == FUNC_TICK) && active_reg;

        pos_next    = pos_reg;
        active_next = active_reg;
        up_next     = up_reg;
        seg_next    = seg_reg;
        speed_next  = speed_reg;
        thr_next    = thr_reg;
        count_next  = count_reg;

        case (item.func)
            FUNC_LOAD: begin
                if (item.table_index == 8'd0) begin
                    count_next = item.table_value;
                end
            end
            FUNC_START: begin
                active_next = 1'b1;
                up_next     = item.count_up;
                seg_next    = 8'd0;
                speed_next  = cfg.initial_speed;
                thr_next    = {1'b0, cfg.initial_steps};
            end
            FUNC_TICK: begin
                if (active_reg) begin
                    pos_next = pos_step;
                    if (halt_hit) begin
                        active_next = 1'b0;
                    end
                    if (ramp_hit) begin
                        seg_next   = seg_reg + 8'd1;
                        thr_next   = thr_reg + {16'd0, seg_steps};
                        speed_next = clamped_speed;
                    end
                end
            end
            default: begin
            end
        endcase

        result.position      = pos_next;
        result.speed         = speed_next;
        result.speed_changed = is_tick && ramp_hit;
        result.halted        = is_tick && halt_hit;
        result.moving        = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            active_reg <= 1'b0;
            up_reg     <= 1'b0;
            seg_reg    <= '0;
            speed_reg  <= '0;
            thr_reg    <= '0;
            count_reg  <= '0;
        end else if (go) begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
            up_reg     <= up_next;
            seg_reg    <= seg_next;
            speed_reg  <= speed_next;
            thr_reg    <= thr_next;
            count_reg  <= count_next;
        end
    end

    assign seg_index = seg_reg;

endmodule

### src/stepper_step_counter_with_ramp_core.sv
// Channel   Dir  Signals                          Word
// s_        in   s_tvalid/s_tready/s_tdata/s_tuser  one command (tick, load, start)
// m_        out  m_tvalid/m_tready/m_tdata         one status word per command
// cfg_      in   cfg_valid/cfg_ready/cfg_index/cfg_data  register write
//
// An accepted word goes through a profile memory read, then a state update into the output register.
// After a tick or start, the next word waits for the segment index write-back that sets its
// profile read address. Loads and the unused code go one per cycle while the output register is free.
// Synchronous active-low reset clears position and motion state; the profile memory
// is not cleared and must be loaded before a move uses it.
// The output register takes a new word while m_tready is low only once it is empty.
module stepper_step_counter_with_ramp_core
    import scr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // count_up, table_index[7:0], table_value[15:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // position[31:0], speed[15:0], speed_changed, halted, moving
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    scr_cfg_t    cfg_reg, cfg_next;
    scr_item_t   in_item;
    scr_item_t   b_item_reg;
    logic        b_valid_reg, b_valid_next;
    logic        m_valid_reg, m_valid_next;
    scr_result_t m_data_reg;
    scr_result_t result;

    logic        out_free, b_advance, b_free, accept;
    logic        b_blocks;
    logic [7:0]  seg_index;
    logic [WADDR_W-1:0] load_addr, speed_addr, steps_addr;
    logic        load_we;
    logic [15:0] seg_speed, seg_steps;

    assign in_item.func        = s_tuser;
    assign in_item.count_up    = s_tdata[0];
    assign in_item.table_index = s_tdata[8:1];
    assign in_item.table_value = s_tdata[24:9];

    assign out_free  = !m_valid_reg || m_tready;
    assign b_advance = b_valid_reg && out_free;
    assign b_free    = !b_valid_reg || b_advance;
    assign b_blocks  = b_valid_reg && ((b_item_reg.func == FUNC_TICK)
                                    || (b_item_reg.func == FUNC_START));
    assign s_tready  = b_free && !b_blocks;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // next segment words: speed at 2s+1, steps at 2s+2 for s = seg_index + 1
    assign load_addr  = {3'd0, in_item.table_index};
    assign load_we    = accept && (in_item.func == FUNC_LOAD)
                        && (load_addr < WADDR_W'(PROFILE_WORDS));
    assign speed_addr = {2'd0, seg_index, 1'b0} + WADDR_W'(3);
    assign steps_addr = {2'd0, seg_index, 1'b0} + WADDR_W'(4);

    scr_profile_ram #(
        .DEPTH (PROFILE_WORDS),
        .WIDTH (16)
    ) u_profile_ram (
        .aclk    (aclk),
        .we      (load_we),
        .waddr   (load_addr[PROFILE_AW-1:0]),
        .wdata   (in_item.table_value),
        .re      (accept),
        .raddr_a (speed_addr[PROFILE_AW-1:0]),
        .raddr_b (steps_addr[PROFILE_AW-1:0]),
        .rdata_a (seg_speed),
        .rdata_b (seg_steps)
    );

    scr_ramp_unit u_ramp_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (b_advance),
        .item      (b_item_reg),
        .cfg       (cfg_reg),
        .seg_speed (seg_speed),
        .seg_steps (seg_steps),
        .seg_index (seg_index),
        .result    (result)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STOP_ENABLE:    cfg_next.stop_enable    = cfg_data[0];
                CFG_MAX_SPEED:      cfg_next.max_speed      = cfg_data[15:0];
                CFG_STOP_POSITION:  cfg_next.stop_position  = cfg_data;
                CFG_START_POSITION: cfg_next.start_position = cfg_data;
                CFG_INITIAL_SPEED:  cfg_next.initial_speed  = cfg_data[15:0];
                CFG_INITIAL_STEPS:  cfg_next.initial_steps  = cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (accept) begin
            b_valid_next = 1'b1;
        end else if (b_advance) begin
            b_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (b_advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_item_reg <= in_item;
        end
        if (b_advance) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> b_valid_reg)
        else $error("accepted word did not reach the update stage");

    a_halt_stops_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.halted) |-> !m_data_reg.moving)
        else $error("halted word still reports motion");

    a_ramp_speed_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        b_advance && result.speed_changed |-> result.speed <= cfg_reg.max_speed)
        else $error("ramped speed above max_speed");

    a_tick_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_item.func == FUNC_TICK)) |=> $past(!b_blocks))
        else $error("tick read the profile ahead of segment write-back");

endmodule
